// ===== src/wfi_pkg.sv =====
// Shared types, format codes and the binary64 rounding function for the frame converter.
package wfi_pkg;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_I16 = 3'd1;
  localparam logic [2:0] FMT_I24 = 3'd2;
  localparam logic [2:0] FMT_I32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;
  localparam logic [2:0] FMT_F64 = 3'd5;

  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [1:0] REG_MONO_MODE     = 2'd1;

  localparam logic [2:0] FMT_RESET  = FMT_I16;
  localparam logic       MONO_RESET = 1'b0;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_F64  = 2'd2;
  localparam logic [1:0] KIND_ZERO = 2'd3;

  // Significand of the single-precision value nearest to 1/127.5.
  localparam logic [23:0] U8_SCALE_SIG = 24'h808081;

  localparam logic [7:0] EBASE_U8  = 8'd96;
  localparam logic [7:0] EBASE_I16 = 8'd112;
  localparam logic [7:0] EBASE_I24 = 8'd104;
  localparam logic [7:0] EBASE_I32 = 8'd96;

  localparam logic [31:0] F32_INF = 32'h7f800000;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } wfi_stage_en_t;

  // Rounds a binary64 pattern to binary32, nearest even.
  function automatic logic [31:0] f64_to_f32(input logic [63:0] w);
    logic               sgn;
    logic [10:0]        ex;
    logic [51:0]        man;
    logic signed [12:0] fe;
    logic [63:0]        sig;
    logic [5:0]         sh;
    logic [63:0]        q;
    logic [63:0]        rem;
    logic [63:0]        half;
    logic               up;
    logic [7:0]         fe_m1;
    logic [32:0]        tot;
    logic [31:0]        r;
    begin
      sgn   = w[63];
      ex    = w[62:52];
      man   = w[51:0];
      fe    = $signed({2'b00, ex}) - 13'sd896;
      sig   = {11'd0, 1'b1, man};
      sh    = (fe >= 13'sd1) ? 6'd29 : 6'(13'sd30 - fe);
      q     = sig >> sh;
      rem   = sig & ((64'd1 << sh) - 64'd1);
      half  = 64'd1 << (sh - 6'd1);
      up    = (rem > half) || ((rem == half) && q[0]);
      q     = q + {63'd0, up};
      fe_m1 = fe[7:0] - 8'd1;
      tot   = {8'd0, q[24:0]} + ({25'd0, fe_m1} << 23);
      r     = {sgn, 31'd0};
      if (ex == 11'h7ff) begin
        if (man == 52'd0) begin
          r = {sgn, F32_INF[30:0]};
        end else begin
          r = {sgn, 9'h1ff, man[50:29]};
        end
      end else if (ex == 11'd0) begin
        r = {sgn, 31'd0};
      end else if (fe >= 13'sd255) begin
        r = {sgn, F32_INF[30:0]};
      end else if (fe >= 13'sd1) begin
        if (tot >= {1'b0, F32_INF}) begin
          r = {sgn, F32_INF[30:0]};
        end else begin
          r = {sgn, tot[30:0]};
        end
      end else if (fe < -13'sd30) begin
        r = {sgn, 31'd0};
      end else begin
        r = {sgn, q[30:0]};
      end
      return r;
    end
  endfunction

endpackage

// ===== src/wav_frame_to_float_iq.sv =====
// Top level of the PCM frame to single-precision I/Q converter.
// Usage: one frame is offered on first_channel_bytes_i and second_channel_bytes_i
// with in_valid_i and is taken when in_ready_o is also high. The I/Q word pair
// appears on inphase_word_o and quadrature_word_o with out_valid_o and leaves
// when out_ready_i is high. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_data_i: index 0 selects the sample format, index 1 the mono mode.
// Each channel has its own three-stage lane: decode and scale, normalise,
// round and pack. The pair is joined at the output, where mono mode copies I
// into Q. An accepted frame moves through the decode, normalise and pack
// registers in turn and is valid once the last one holds it; one frame is taken
// every cycle while the receiver keeps up.
// Each stage holds its word until the next one is free, so a stalled receiver
// lets the earlier stages keep filling; in_ready_o falls only once all three
// stages hold a word. Reset empties the pipeline and sets the format to signed
// 16-bit and the mode to stereo.
module wav_frame_to_float_iq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] first_channel_bytes_i,
  input  logic [63:0] second_channel_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] inphase_word_o,
  output logic [31:0] quadrature_word_o
);

  logic [2:0] fmt_q;
  logic       mono_q;
  logic       va_q, vb_q, vc_q;
  wfi_pkg::wfi_stage_en_t en;
  logic [31:0] i_word, q_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= wfi_pkg::FMT_RESET;
      mono_q <= wfi_pkg::MONO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wfi_pkg::REG_SAMPLE_FORMAT: fmt_q  <= cfg_data_i;
        wfi_pkg::REG_MONO_MODE:     mono_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en.c = !vc_q || out_ready_i;
    en.b = !vb_q || en.c;
    en.a = !va_q || en.b;
  end

  assign in_ready_o = en.a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en.a) begin
        va_q <= in_valid_i;
      end
      if (en.b) begin
        vb_q <= va_q;
      end
      if (en.c) begin
        vc_q <= vb_q;
      end
    end
  end

  wfi_lane u_lane_i (
    .clk_i    (clk_i),
    .en_i     (en),
    .fmt_i    (fmt_q),
    .word_i   (first_channel_bytes_i),
    .result_o (i_word)
  );

  wfi_lane u_lane_q (
    .clk_i    (clk_i),
    .en_i     (en),
    .fmt_i    (fmt_q),
    .word_i   (second_channel_bytes_i),
    .result_o (q_word)
  );

  assign out_valid_o       = vc_q;
  assign inphase_word_o    = i_word;
  assign quadrature_word_o = mono_q ? i_word : q_word;

endmodule

// ===== src/wfi_lane.sv =====
// One conversion lane: decode and scale, normalise, then round and pack to single precision.
module wfi_lane (
  input  logic                  clk_i,
  input  wfi_pkg::wfi_stage_en_t en_i,
  input  logic [2:0]            fmt_i,
  input  logic [63:0]           word_i,
  output logic [31:0]           result_o
);

  logic [1:0]  kind_a_q, kind_a_d;
  logic        sign_a_q, sign_a_d;
  logic [31:0] mag_a_q, mag_a_d;
  logic [7:0]  ebase_a_q, ebase_a_d;
  logic [63:0] raw_a_q;

  logic        direct_b_q, direct_b_d;
  logic [31:0] dword_b_q, dword_b_d;
  logic        sign_b_q;
  logic [7:0]  exp_b_q, exp_b_d;
  logic [31:0] norm_b_q, norm_b_d;

  logic [31:0] result_q, result_d;

  logic [31:0] ext16, ext24;
  logic [7:0]  kmag;
  logic [4:0]  lead;
  logic        rnd_up;

  always_comb begin
    ext16     = {{16{word_i[15]}}, word_i[15:0]};
    ext24     = {{8{word_i[23]}}, word_i[23:0]};
    kmag      = word_i[7] ? {word_i[6:0], 1'b1} : {~word_i[6:0], 1'b1};
    kind_a_d  = wfi_pkg::KIND_ZERO;
    sign_a_d  = 1'b0;
    mag_a_d   = 32'd0;
    ebase_a_d = wfi_pkg::EBASE_I32;
    case (fmt_i)
      wfi_pkg::FMT_U8: begin
        kind_a_d  = wfi_pkg::KIND_INT;
        sign_a_d  = ~word_i[7];
        mag_a_d   = {24'd0, kmag} * {8'd0, wfi_pkg::U8_SCALE_SIG};
        ebase_a_d = wfi_pkg::EBASE_U8;
      end
      wfi_pkg::FMT_I16: begin
        kind_a_d  = wfi_pkg::KIND_INT;
        sign_a_d  = word_i[15];
        mag_a_d   = word_i[15] ? 32'd0 - ext16 : ext16;
        ebase_a_d = wfi_pkg::EBASE_I16;
      end
      wfi_pkg::FMT_I24: begin
        kind_a_d  = wfi_pkg::KIND_INT;
        sign_a_d  = word_i[23];
        mag_a_d   = word_i[23] ? 32'd0 - ext24 : ext24;
        ebase_a_d = wfi_pkg::EBASE_I24;
      end
      wfi_pkg::FMT_I32: begin
        kind_a_d  = wfi_pkg::KIND_INT;
        sign_a_d  = word_i[31];
        mag_a_d   = word_i[31] ? 32'd0 - word_i[31:0] : word_i[31:0];
        ebase_a_d = wfi_pkg::EBASE_I32;
      end
      wfi_pkg::FMT_F32: kind_a_d = wfi_pkg::KIND_PASS;
      wfi_pkg::FMT_F64: kind_a_d = wfi_pkg::KIND_F64;
      default:          kind_a_d = wfi_pkg::KIND_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      kind_a_q  <= kind_a_d;
      sign_a_q  <= sign_a_d;
      mag_a_q   <= mag_a_d;
      ebase_a_q <= ebase_a_d;
      raw_a_q   <= word_i;
    end
  end

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag_a_q[i]) begin
        lead = 5'(i);
      end
    end
    norm_b_d   = mag_a_q << (5'd31 - lead);
    exp_b_d    = ebase_a_q + {3'd0, lead};
    direct_b_d = 1'b1;
    dword_b_d  = 32'd0;
    case (kind_a_q)
      wfi_pkg::KIND_INT: begin
        direct_b_d = (mag_a_q == 32'd0);
      end
      wfi_pkg::KIND_PASS: dword_b_d = raw_a_q[31:0];
      wfi_pkg::KIND_F64:  dword_b_d = wfi_pkg::f64_to_f32(raw_a_q);
      default:            dword_b_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      direct_b_q <= direct_b_d;
      dword_b_q  <= dword_b_d;
      sign_b_q   <= sign_a_q;
      exp_b_q    <= exp_b_d;
      norm_b_q   <= norm_b_d;
    end
  end

  always_comb begin
    rnd_up = norm_b_q[7] & ((|norm_b_q[6:0]) | norm_b_q[8]);
    if (direct_b_q) begin
      result_d = dword_b_q;
    end else begin
      result_d = {sign_b_q, {exp_b_q, norm_b_q[30:8]} + {30'd0, rnd_up}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== src/wfi_checker.sv =====
// Port-level checks for the frame converter and their binding to the top level.
module wfi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] inphase_word_o,
  input logic [31:0] quadrature_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(inphase_word_o) && $stable(quadrature_word_o))
    else $error("Output word changed while stalled.");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input refused with an empty output stage.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("Accepted word did not reach the output in three cycles.");

endmodule

bind wav_frame_to_float_iq wfi_checker u_wfi_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .inphase_word_o    (inphase_word_o),
  .quadrature_word_o (quadrature_word_o)
);

// ===== tb/wfi_iq_checker.sv =====
// Scoreboard for the frame converter: tracks configuration, predicts I/Q words and compares.
`timescale 1ns / 100ps
module wfi_iq_checker
  import wfi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] first_channel_bytes_i,
  input  logic [63:0] second_channel_bytes_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] inphase_word_i,
  input  logic [31:0] quadrature_word_i,
  output int          pending_o,
  output int          errors_o,
  output int          words_checked_o
);

  // Single-precision value nearest to 1/127.5, held exactly as a double.
  localparam real U8_STEP = 8421505.0 / 1073741824.0;

  typedef struct packed {
    logic [31:0] inphase;
    logic [31:0] quadrature;
  } iq_pair_t;

  logic [2:0] sample_format_q;
  logic       mono_q;
  iq_pair_t   iq_expected[$];

  function automatic logic [31:0] narrow_double(input logic [63:0] d);
    logic        s;
    logic [10:0] e;
    logic [52:0] sig;
    int          ue;
    int          sh;
    logic [63:0] q;
    logic [63:0] rest;
    logic [63:0] halfw;
    s   = d[63];
    e   = d[62:52];
    sig = {1'b1, d[51:0]};
    if (e == 11'h7ff) begin
      if (d[51:0] == 52'd0) return {s, 8'hff, 23'd0};
      return {s, 8'hff, 1'b1, d[50:29]};
    end
    if (e == 11'd0) return {s, 31'd0};
    ue = int'(e) - 1023;
    if (ue > 127) return {s, 8'hff, 23'd0};
    sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
    if (sh > 62) return {s, 31'd0};
    q     = 64'(sig) >> sh;
    rest  = 64'(sig) & ((64'd1 << sh) - 64'd1);
    halfw = 64'd1 << (sh - 1);
    if (rest > halfw || (rest == halfw && q[0])) q = q + 64'd1;
    if (ue >= -126) q = q + (64'(ue + 126) << 23);
    if (q >= 64'h7f800000) return {s, 8'hff, 23'd0};
    return {s, q[30:0]};
  endfunction

  function automatic logic [31:0] sample_to_single(input logic [2:0] fmt, input logic [63:0] w);
    real r;
    case (fmt)
      FMT_U8: begin
        r = (real'(w[7:0]) - 127.5) * U8_STEP;
        return narrow_double($realtobits(r));
      end
      FMT_I16: begin
        r = real'(longint'($signed(w[15:0]))) / 32768.0;
        return narrow_double($realtobits(r));
      end
      FMT_I24: begin
        r = real'(longint'($signed(w[23:0]))) / 8388608.0;
        return narrow_double($realtobits(r));
      end
      FMT_I32: begin
        r = real'(longint'($signed(w[31:0]))) / 2147483648.0;
        return narrow_double($realtobits(r));
      end
      FMT_F32: return w[31:0];
      FMT_F64: return narrow_double(w);
      default: return 32'd0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    iq_pair_t want;
    if (!rst_ni) begin
      sample_format_q <= FMT_RESET;
      mono_q          <= MONO_RESET;
      iq_expected.delete();
      errors_o        <= 0;
      words_checked_o <= 0;
      pending_o       <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SAMPLE_FORMAT) sample_format_q <= cfg_data_i;
        else if (cfg_idx_i == REG_MONO_MODE) mono_q <= cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i) begin
        want.inphase    = sample_to_single(sample_format_q, first_channel_bytes_i);
        want.quadrature = mono_q ? want.inphase
                                 : sample_to_single(sample_format_q, second_channel_bytes_i);
        iq_expected.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        words_checked_o <= words_checked_o + 1;
        if (iq_expected.size() == 0) begin
          $error("unexpected word: inphase_word %h quadrature_word %h",
                 inphase_word_i, quadrature_word_i);
          errors_o <= errors_o + 1;
        end else begin
          want = iq_expected.pop_front();
          if (want.inphase !== inphase_word_i || want.quadrature !== quadrature_word_i) begin
            if (want.inphase !== inphase_word_i)
              $error("inphase_word: expected %h, actual %h", want.inphase, inphase_word_i);
            if (want.quadrature !== quadrature_word_i)
              $error("quadrature_word: expected %h, actual %h",
                     want.quadrature, quadrature_word_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= iq_expected.size();
    end
  end

endmodule

// ===== tb/tb_wav_frame_to_float_iq.sv =====
// Testbench top for the frame converter: clock, reset, stimulus, handshake pressure and verdict.
`timescale 1ns / 100ps
module tb_wav_frame_to_float_iq;
  import wfi_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [2:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] first_channel_bytes_i = '0;
  logic [63:0] second_channel_bytes_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] inphase_word_o;
  logic [31:0] quadrature_word_o;

  int pending;
  int errors;
  int words_checked;
  int stall_cycles = 0;
  int idle_cycles = 0;
  int frames_sent = 0;
  int settings_used = 0;
  bit quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  wav_frame_to_float_iq dut (.*);

  wfi_iq_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .first_channel_bytes_i, .second_channel_bytes_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .inphase_word_i(inphase_word_o), .quadrature_word_i(quadrature_word_o),
    .pending_o(pending), .errors_o(errors), .words_checked_o(words_checked)
  );

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_cycles > 0) begin
        stall_cycles = stall_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("tb_wav_frame_to_float_iq: errors");
      $finish;
    end
  end

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    logic [10:0] e;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: e = 11'd896 + 11'($urandom_range(4)) - 11'd2;
      1: e = 11'd1150 + 11'($urandom_range(4)) - 11'd2;
      2: e = 11'd873 + 11'($urandom_range(6)) - 11'd3;
      3: e = ($urandom_range(1)) ? 11'h7ff : 11'd0;
      default: e = w[62:52];
    endcase
    if ($urandom_range(3) == 0) w[28:0] = {1'b1, 28'd0};
    if ($urandom_range(7) == 0) w[51:29] = '1;
    w[62:52] = e;
    return w;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(input logic [63:0] a, input logic [63:0] b);
    if (!quiet && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    first_channel_bytes_i  <= a;
    second_channel_bytes_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frames_sent++;
  endtask

  initial begin
    logic [63:0] edge_words[6];
    logic [2:0]  fmt;
    edge_words = '{64'd0, '1, 64'h8000_0000_0000_0080, 64'h7fff_ffff_ffff_ff7f,
                   64'h7ff0_0000_0000_0000, 64'h36a0_0000_1000_0000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int f = 0; f < 6; f++) begin
      if (f != 1) write_reg(REG_SAMPLE_FORMAT, 3'(f));
      for (int k = 0; k < 4; k++)
        send_frame(edge_words[(k + f) % 6], edge_words[(k + f + 3) % 6]);
    end
    write_reg(REG_SAMPLE_FORMAT, FMT_F64);
    send_frame(64'hfff8_0000_2000_0000, 64'h47f0_0000_0000_0000);
    send_frame(64'h380f_ffff_f000_0000, 64'h8000_0000_0000_0001);

    for (int p = 0; p < 14; p++) begin
      in_valid_i <= 1'b0;
      fmt = (p < 8) ? 3'(p) : 3'($urandom_range(7));
      write_reg(REG_SAMPLE_FORMAT, fmt);
      write_reg(REG_MONO_MODE, 3'($urandom_range(7)));
      if (p % 5 == 2) write_reg(2'($urandom_range(3, 2)), 3'($urandom_range(7)));
      quiet = (p == 3);
      if (p == 5) stall_cycles = 80;
      for (int n = 0; n < 125; n++) begin
        if (p == 7 && n == 60) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_frame(random_word(), random_word());
      end
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d frames over %0d register writes; %0d I/Q words compared.",
             frames_sent, settings_used, words_checked);
    if (errors == 0) begin
      $display("tb_wav_frame_to_float_iq: clean");
    end else begin
      $display("tb_wav_frame_to_float_iq: errors");
    end
    $finish;
  end

endmodule

// ===== wav_frame_to_float_iq.f =====
src/wfi_pkg.sv
src/wfi_lane.sv
src/wav_frame_to_float_iq.sv
src/wfi_checker.sv
tb/wfi_iq_checker.sv
tb/tb_wav_frame_to_float_iq.sv
